// File: rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared widths, codes and types of the bitmap frame allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfa_pkg;

  // Bitmap geometry: one bit per frame, 64 frames per memory word
  localparam int unsigned MaxFrames = 65536;
  localparam int unsigned WordW     = 64;
  localparam int unsigned Words     = MaxFrames / WordW;
  localparam int unsigned WordAw    = $clog2(Words);
  localparam int unsigned BitAw     = $clog2(WordW);
  localparam int unsigned MaxRun    = 64;

  // Field widths
  localparam int unsigned FrameW  = 16;
  localparam int unsigned CountW  = 7;
  localparam int unsigned FcountW = 17;
  localparam int unsigned UsedW   = 17;
  localparam int unsigned CfgIdxW = 1;

  typedef logic [WordW-1:0] word_t;

  // Request kinds
  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_BLOCK  = 2'd1,
    STATUS_BAD_COUNT = 2'd2,
    STATUS_NULL_FREE = 2'd3
  } status_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_COUNT  = 1'b0,
    REG_SEARCH_START = 1'b1
  } cfg_reg_e;

  // Rounded block size of an allocation
  typedef enum logic [2:0] {
    SZ_1  = 3'd0,
    SZ_8  = 3'd1,
    SZ_16 = 3'd2,
    SZ_32 = 3'd3,
    SZ_64 = 3'd4
  } blk_size_e;

endpackage

// File: rtl/bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// Sequence: a free writes its bitmap word back, then gives its result; a rejected
//   request goes straight to the result state; allocate scans, then writes back.
// Throughput: one request at a time; the scan reads one 64-bit word per cycle
//   from the single read port of the bitmap memory.
// Reset: a clearing pass marks every frame used; no request is taken before it
//   ends, configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_frame_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bfa_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bfa_pkg::FcountW-1:0]  cfg_data_i,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         req_type_i,
  input  logic [bfa_pkg::CountW-1:0]   count_i,
  input  logic [bfa_pkg::FrameW-1:0]   frame_index_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [bfa_pkg::FrameW-1:0]   base_frame_o,
  output logic [bfa_pkg::UsedW-1:0]    used_frames_o
);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_FREE_WR  = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_ALLOC_WR = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  localparam int unsigned WordAw  = bfa_pkg::WordAw;
  localparam int unsigned BitAw   = bfa_pkg::BitAw;
  localparam int unsigned FcountW = bfa_pkg::FcountW;
  localparam int unsigned UsedW   = bfa_pkg::UsedW;
  localparam int unsigned FrameW  = bfa_pkg::FrameW;
  localparam int unsigned WcntW   = FcountW - BitAw;

  localparam logic [FcountW-1:0] LimitMax = FcountW'(bfa_pkg::MaxFrames);
  localparam logic [UsedW-1:0]   UsedMax  = {UsedW{1'b1}};
  localparam logic [WordAw-1:0]  LastWord = WordAw'(bfa_pkg::Words - 1);
  localparam bfa_pkg::word_t     AllOnes  = {bfa_pkg::WordW{1'b1}};

  logic [2:0] state_q, state_d;

  // configuration registers
  logic [FcountW-1:0] frame_count_q;
  logic [FrameW-1:0]  search_start_q;

  // request and scan registers
  logic [WordAw-1:0]            clr_q;
  logic [UsedW-1:0]             used_q;
  logic [bfa_pkg::CountW-1:0]   cnt_q;
  logic [FrameW-1:0]            frm_q;
  bfa_pkg::blk_size_e           sz_q;
  logic [WcntW-1:0]             iss_w_q;
  logic [WcntW-1:0]             last_q;
  logic [WcntW-1:0]             fend_q;
  logic [WordAw-1:0]            start_w_q;
  logic [WordAw-1:0]            pend_w_q;
  logic                         pend_q;
  logic                         hit_q;
  logic [2:0]                   lo_q;
  logic [2:0]                   lim_b_q;
  bfa_pkg::word_t               word_q;
  logic [FrameW-1:0]            base_q;
  bfa_pkg::status_e             res_status_q;
  logic [FrameW-1:0]            res_base_q;

  // output register
  logic                         out_valid_q;
  logic [1:0]                   out_status_q;
  logic [FrameW-1:0]            out_base_q;
  logic [UsedW-1:0]             out_used_q;

  // bitmap memory
  bfa_pkg::word_t               mem_q [bfa_pkg::Words];
  bfa_pkg::word_t               rdata_q;
  logic                         mem_re;
  logic [WordAw-1:0]            mem_ra;
  logic                         mem_we;
  logic [WordAw-1:0]            mem_wa;
  bfa_pkg::word_t               mem_wd;

  // combinational helpers
  logic                         acc;
  logic                         out_free;
  logic [FcountW-1:0]           limit;
  bfa_pkg::blk_size_e           sz_in;
  logic                         has_part;
  logic [2:0]                   lo_in;
  logic                         cnt_big;
  logic                         exhausted;
  logic                         issue;
  logic                         full_w;
  logic                         first_w;
  logic [3:0]                   nb;
  logic [7:0]                   fv8;
  logic [3:0]                   fv16;
  logic [1:0]                   fv32;
  logic [7:0]                   cand;
  logic [7:0]                   hits;
  logic [2:0]                   byte_idx;
  logic [BitAw-1:0]             bit_idx;
  logic                         found;
  logic [BitAw-1:0]             found_off;
  bfa_pkg::word_t               zero_bits;
  bfa_pkg::word_t               run_mask;
  logic [UsedW:0]               used_sum;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign acc         = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign base_frame_o  = out_base_q;
  assign used_frames_o = out_used_q;

  // Clamp the managed frame count to the bitmap size
  assign limit = (frame_count_q > LimitMax) ? LimitMax : frame_count_q;

  // Decode the incoming request: block size, scan bounds
  always_comb begin
    cnt_big = count_i > bfa_pkg::CountW'(bfa_pkg::MaxRun);
    if (count_i == bfa_pkg::CountW'(1)) begin
      sz_in = bfa_pkg::SZ_1;
    end else if (count_i <= bfa_pkg::CountW'(8)) begin
      sz_in = bfa_pkg::SZ_8;
    end else if (count_i <= bfa_pkg::CountW'(16)) begin
      sz_in = bfa_pkg::SZ_16;
    end else if (count_i <= bfa_pkg::CountW'(32)) begin
      sz_in = bfa_pkg::SZ_32;
    end else begin
      sz_in = bfa_pkg::SZ_64;
    end
    has_part = (limit[BitAw-1:0] != '0) &&
               (sz_in == bfa_pkg::SZ_8 || sz_in == bfa_pkg::SZ_16 ||
                sz_in == bfa_pkg::SZ_32);
    unique case (sz_in)
      bfa_pkg::SZ_16: lo_in = {search_start_q[5:4], 1'b0};
      bfa_pkg::SZ_32: lo_in = {search_start_q[5], 2'b00};
      default:        lo_in = 3'd0;
    endcase
  end

  // Evaluate the word that came back from the memory
  always_comb begin
    logic lo_ok;
    logic hi_ok;
    case (sz_q)
      bfa_pkg::SZ_16: nb = 4'd2;
      bfa_pkg::SZ_32: nb = 4'd4;
      bfa_pkg::SZ_64: nb = 4'd8;
      default:        nb = 4'd1;
    endcase
    full_w  = {1'b0, pend_w_q} < fend_q;
    first_w = (pend_w_q == start_w_q);
    for (int j = 0; j < 8; j++) begin
      fv8[j] = (rdata_q[8*j +: 8] == 8'h00);
    end
    for (int k = 0; k < 4; k++) begin
      fv16[k] = &fv8[2*k +: 2];
    end
    for (int k = 0; k < 2; k++) begin
      fv32[k] = &fv8[4*k +: 4];
    end
    case (sz_q)
      bfa_pkg::SZ_16: cand = {1'b0, fv16[3], 1'b0, fv16[2], 1'b0, fv16[1], 1'b0, fv16[0]};
      bfa_pkg::SZ_32: cand = {3'b000, fv32[1], 3'b000, fv32[0]};
      bfa_pkg::SZ_64: cand = {7'd0, &fv8};
      default:        cand = fv8;
    endcase
    for (int j = 0; j < 8; j++) begin
      lo_ok   = !first_w || (3'(j) >= lo_q);
      hi_ok   = full_w || ((4'(j) + nb) <= {1'b0, lim_b_q});
      hits[j] = cand[j] && lo_ok && hi_ok;
    end
    // lowest free block in the word
    byte_idx = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (hits[j]) begin
        byte_idx = 3'(j);
      end
    end
    // lowest free frame in the word
    zero_bits = ~rdata_q;
    bit_idx   = '0;
    for (int i = bfa_pkg::WordW - 1; i >= 0; i--) begin
      if (zero_bits[i]) begin
        bit_idx = BitAw'(i);
      end
    end
    // an 8-block in the tail word needs an earlier word that was not full
    if (sz_q == bfa_pkg::SZ_1) begin
      found     = (zero_bits != '0);
      found_off = bit_idx;
    end else begin
      found     = (hits != 8'h00) && (full_w || hit_q || sz_q != bfa_pkg::SZ_8);
      found_off = {byte_idx, 3'b000};
    end
  end

  assign exhausted = (iss_w_q >= last_q);
  assign issue     = (state_q == S_SCAN) && !exhausted;

  // Build the run mask and the saturated counter sum
  always_comb begin
    bfa_pkg::word_t low_mask;
    if (cnt_q[bfa_pkg::CountW-1]) begin
      low_mask = AllOnes;
    end else begin
      low_mask = (bfa_pkg::word_t'(1) << cnt_q[BitAw-1:0]) - bfa_pkg::word_t'(1);
    end
    run_mask = low_mask << base_q[BitAw-1:0];
    used_sum = {1'b0, used_q} + (UsedW+1)'(cnt_q);
  end

  // Select the memory ports
  always_comb begin
    mem_re = issue || acc;
    mem_ra = (state_q == S_SCAN) ? iss_w_q[WordAw-1:0] : frame_index_i[FrameW-1:BitAw];
    mem_we = 1'b0;
    mem_wa = clr_q;
    mem_wd = AllOnes;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_FREE_WR: begin
        mem_we = 1'b1;
        mem_wa = frm_q[FrameW-1:BitAw];
        mem_wd = rdata_q & ~(bfa_pkg::word_t'(1) << frm_q[BitAw-1:0]);
      end
      S_ALLOC_WR: begin
        mem_we = 1'b1;
        mem_wa = base_q[FrameW-1:BitAw];
        mem_wd = word_q | run_mask;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == LastWord) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          if (req_type_i == bfa_pkg::REQ_FREE) begin
            state_d = (frame_index_i == '0) ? S_DONE : S_FREE_WR;
          end else if (count_i == '0 || cnt_big) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_FREE_WR:  state_d = S_DONE;
      S_SCAN: begin
        if (pend_q && found) begin
          state_d = S_ALLOC_WR;
        end else if (exhausted) begin
          state_d = S_DONE;
        end
      end
      S_ALLOC_WR: state_d = S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      clr_q          <= '0;
      frame_count_q  <= LimitMax;
      search_start_q <= '0;
      used_q         <= '0;
      pend_q         <= 1'b0;
      hit_q          <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      // advance the clearing pass
      if (state_q == S_CLEAR) clr_q <= clr_q + WordAw'(1);

      // take configuration writes
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          bfa_pkg::REG_FRAME_COUNT:  frame_count_q  <= cfg_data_i;
          bfa_pkg::REG_SEARCH_START: search_start_q <= cfg_data_i[FrameW-1:0];
          default: ;
        endcase
      end

      // update the used counter
      if (state_q == S_FREE_WR && used_q != '0) begin
        used_q <= used_q - UsedW'(1);
      end else if (state_q == S_ALLOC_WR) begin
        used_q <= (used_sum > {1'b0, UsedMax}) ? UsedMax : used_sum[UsedW-1:0];
      end

      // track the scan pipeline
      if (acc) begin
        pend_q <= 1'b0;
        hit_q  <= 1'b0;
      end else if (state_q == S_SCAN) begin
        pend_q <= issue;
        if (pend_q && full_w && rdata_q != AllOnes) hit_q <= 1'b1;
      end

      // hold the result until taken
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (acc) begin
      cnt_q     <= count_i;
      frm_q     <= frame_index_i;
      sz_q      <= sz_in;
      iss_w_q   <= {1'b0, search_start_q[FrameW-1:BitAw]};
      start_w_q <= search_start_q[FrameW-1:BitAw];
      fend_q    <= limit[FcountW-1:BitAw];
      last_q    <= limit[FcountW-1:BitAw] + WcntW'(has_part);
      lo_q      <= lo_in;
      lim_b_q   <= limit[BitAw-1:3];
      res_base_q <= '0;
      if (req_type_i == bfa_pkg::REQ_FREE) begin
        res_status_q <= (frame_index_i == '0) ? bfa_pkg::STATUS_NULL_FREE
                                              : bfa_pkg::STATUS_OK;
      end else begin
        res_status_q <= cnt_big ? bfa_pkg::STATUS_BAD_COUNT : bfa_pkg::STATUS_OK;
      end
    end
    if (state_q == S_SCAN) begin
      if (issue) begin
        iss_w_q  <= iss_w_q + WcntW'(1);
        pend_w_q <= iss_w_q[WordAw-1:0];
      end
      if (pend_q && found) begin
        word_q <= rdata_q;
        base_q <= {pend_w_q, found_off};
      end else if (exhausted) begin
        res_status_q <= bfa_pkg::STATUS_NO_BLOCK;
      end
    end
    if (state_q == S_ALLOC_WR) begin
      res_status_q <= bfa_pkg::STATUS_OK;
      res_base_q   <= base_q;
    end
    if (state_q == S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_base_q   <= res_base_q;
      out_used_q   <= used_q;
    end
  end

  // Bitmap memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (mem_re) rdata_q <= mem_q[mem_ra];
  end

`ifndef NO_ASSERTIONS
  // no request is taken during the clearing pass
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> in_stall_o)
    else $error("request taken during clearing pass");

  // the bitmap is not written while a scan reads it
  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !mem_we)
    else $error("bitmap written during scan");

  // a found block is aligned to its size
  a_block_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC_WR) |->
      (sz_q == bfa_pkg::SZ_1) || (base_q[2:0] == 3'd0))
    else $error("allocated block misaligned");

  // the counter moves only on a free or allocate write-back
  a_used_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_FREE_WR && state_q != S_ALLOC_WR) |=> $stable(used_q))
    else $error("used counter changed outside write-back");
`endif

endmodule

// File: sim/tb_bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// tb_bitmap_frame_allocator
// Self-checking bench for the bitmap frame allocator. A queue-fed driver sends
// allocate and free requests with random gaps, and a monitor stalls the result
// channel at random. Each result is checked against a bit-level model of the
// frame bitmap and used counter. The run covers directed corner requests and
// then random phases under several frame_count / search_start settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bitmap_frame_allocator;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned UsedMax    = (1 << bfa_pkg::UsedW) - 1;

  typedef struct packed {
    bfa_pkg::req_e              kind;
    logic [bfa_pkg::CountW-1:0] count;
    logic [bfa_pkg::FrameW-1:0] frame;
  } request_t;

  typedef struct packed {
    bfa_pkg::status_e           status;
    logic [bfa_pkg::FrameW-1:0] base;
    logic [bfa_pkg::UsedW-1:0]  used;
  } answer_t;

  logic                        clk_i;
  logic                        rst_ni        = 1'b0;
  logic                        cfg_valid_i   = 1'b0;
  logic                        cfg_ready_o;
  logic [bfa_pkg::CfgIdxW-1:0] cfg_index_i   = '0;
  logic [bfa_pkg::FcountW-1:0] cfg_data_i    = '0;
  logic                        in_valid_i    = 1'b0;
  logic                        in_stall_o;
  logic                        req_type_i    = 1'b0;
  logic [bfa_pkg::CountW-1:0]  count_i       = '0;
  logic [bfa_pkg::FrameW-1:0]  frame_index_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i   = 1'b0;
  logic [1:0]                  status_o;
  logic [bfa_pkg::FrameW-1:0]  base_frame_o;
  logic [bfa_pkg::UsedW-1:0]   used_frames_o;

  // Model state: frame bitmap, used counter and register copies
  bfa_pkg::word_t              frame_map [bfa_pkg::Words];
  int unsigned                 used_total;
  logic [bfa_pkg::FcountW-1:0] fcount_cfg;
  logic [bfa_pkg::FrameW-1:0]  start_cfg;

  request_t req_backlog [$];
  answer_t  due_results [$];

  bit          gaps_on   = 1'b1;
  bit          stalls_on = 1'b1;
  int unsigned send_gap  = 0;
  int unsigned stall_left = 0;
  int unsigned cycles    = 0;
  int unsigned errors    = 0;
  int unsigned sent      = 0;
  int unsigned checked   = 0;
  int unsigned placed    = 0;
  int unsigned refused   = 0;
  int unsigned cfg_writes = 0;

  bitmap_frame_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .count_i       (count_i),
    .frame_index_i (frame_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .base_frame_o  (base_frame_o),
    .used_frames_o (used_frames_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Mostly no idle, sometimes a few cycles, rarely a long stretch
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic bfa_pkg::word_t span_bits(int unsigned base, int unsigned size);
    if (size >= bfa_pkg::WordW) return '1;
    return ((bfa_pkg::word_t'(1) << size) - bfa_pkg::word_t'(1)) << (base % bfa_pkg::WordW);
  endfunction

  function automatic bit block_free(int unsigned base, int unsigned size);
    return (frame_map[base / bfa_pkg::WordW] & span_bits(base, size)) == '0;
  endfunction

  // Locate the first free aligned block of the rounded size below the limit
  function automatic bit find_block(int unsigned size, output int unsigned at);
    int unsigned lim, i, word, sh;
    bit hit;
    lim  = (fcount_cfg < bfa_pkg::MaxFrames) ? fcount_cfg : bfa_pkg::MaxFrames;
    hit  = 1'b0;
    at   = 0;
    word = 0;
    if (size <= 8) begin
      // small runs start from the first word that is not full
      for (i = start_cfg / bfa_pkg::WordW; i < lim / bfa_pkg::WordW && !hit; i++)
        if (frame_map[i] != '1) begin
          word = i;
          hit  = 1'b1;
        end
      if (!hit) return 1'b0;
      hit = 1'b0;
      if (size == 1) begin
        for (i = word * bfa_pkg::WordW; i < lim && !hit; i++)
          if (block_free(i, 1)) begin
            at  = i;
            hit = 1'b1;
          end
      end else begin
        for (i = word * 8; i < lim / 8 && !hit; i++)
          if (block_free(i * 8, 8)) begin
            at  = i * 8;
            hit = 1'b1;
          end
      end
    end else begin
      sh = (size == 16) ? 4 : (size == 32) ? 5 : 6;
      for (i = start_cfg >> sh; i < (lim >> sh) && !hit; i++)
        if (block_free(i << sh, size)) begin
          at  = i << sh;
          hit = 1'b1;
        end
    end
    return hit;
  endfunction

  // Apply one request to the model bitmap and return the expected result
  function automatic answer_t serve_request(bfa_pkg::req_e kind,
                                            logic [bfa_pkg::CountW-1:0] cnt,
                                            logic [bfa_pkg::FrameW-1:0] frm);
    answer_t     ans;
    int unsigned size, at;
    ans.status = bfa_pkg::STATUS_OK;
    ans.base   = '0;
    if (kind == bfa_pkg::REQ_FREE) begin
      if (frm == '0) begin
        ans.status = bfa_pkg::STATUS_NULL_FREE;
      end else begin
        if (used_total != 0) used_total--;
        frame_map[frm / bfa_pkg::WordW][frm % bfa_pkg::WordW] = 1'b0;
      end
    end else if (cnt == '0) begin
      // zero count places nothing
    end else if (cnt > bfa_pkg::MaxRun) begin
      ans.status = bfa_pkg::STATUS_BAD_COUNT;
    end else begin
      size = (cnt == 1) ? 1 : (cnt <= 8) ? 8 : (cnt <= 16) ? 16 : (cnt <= 32) ? 32 : 64;
      if (find_block(size, at)) begin
        frame_map[at / bfa_pkg::WordW] |= span_bits(at, cnt);
        used_total = (used_total + cnt > UsedMax) ? UsedMax : used_total + cnt;
        ans.base   = at[bfa_pkg::FrameW-1:0];
        placed++;
      end else begin
        ans.status = bfa_pkg::STATUS_NO_BLOCK;
        refused++;
      end
    end
    ans.used = used_total[bfa_pkg::UsedW-1:0];
    return ans;
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR %0t ns: %s", $time, what);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s is %0h, expected %0h", checked, name, got, want));
  endtask

  // Request driver: send the backlog, idle at random after each transaction
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    logic     take;
    request_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      take = in_valid_i && !in_stall_o;
      if (take) begin
        due_results.push_back(serve_request(bfa_pkg::req_e'(req_type_i), count_i,
                                            frame_index_i));
        sent++;
        send_gap = gaps_on ? idle_length() : 0;
      end
      if (take || !in_valid_i) begin
        if (send_gap == 0 && req_backlog.size() != 0) begin
          nxt = req_backlog.pop_front();
          in_valid_i    <= 1'b1;
          req_type_i    <= nxt.kind;
          count_i       <= nxt.count;
          frame_index_i <= nxt.frame;
        end else begin
          in_valid_i <= 1'b0;
          if (send_gap != 0) send_gap--;
        end
      end
    end
  end

  // Result monitor: check each transaction, stall at random
  always @(posedge clk_i or negedge rst_ni) begin : watch_results
    answer_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = due_results.pop_front();
          check_field("status", 32'(status_o), 32'(want.status));
          check_field("base_frame", 32'(base_frame_o), 32'(want.base));
          check_field("used_frames", 32'(used_frames_o), 32'(want.used));
        end
        checked++;
      end
      if (stall_left == 0 && stalls_on) stall_left = idle_length();
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  function automatic request_t free_req(int unsigned frm);
    request_t rq;
    rq.kind  = bfa_pkg::REQ_FREE;
    rq.count = bfa_pkg::CountW'($urandom_range(0, 127));
    rq.frame = frm[bfa_pkg::FrameW-1:0];
    return rq;
  endfunction

  function automatic request_t alloc_req(int unsigned cnt);
    request_t rq;
    rq.kind  = bfa_pkg::REQ_ALLOC;
    rq.count = cnt[bfa_pkg::CountW-1:0];
    rq.frame = bfa_pkg::FrameW'($urandom_range(0, 65535));
    return rq;
  endfunction

  // Spread allocation sizes over every rounded block class
  function automatic int unsigned pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return 1;
    if (r < 55) return $urandom_range(2, 8);
    if (r < 75) return $urandom_range(9, 16);
    if (r < 90) return $urandom_range(17, 32);
    return $urandom_range(33, 64);
  endfunction

  task automatic write_reg(bfa_pkg::cfg_reg_e idx, logic [bfa_pkg::FcountW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == bfa_pkg::REG_FRAME_COUNT) fcount_cfg = value;
    else start_cfg = value[bfa_pkg::FrameW-1:0];
    cfg_writes++;
  endtask

  // Hold off until every queued request is sent and answered
  task automatic drain();
    @(negedge clk_i);
    while (req_backlog.size() != 0 || in_valid_i || due_results.size() != 0)
      @(negedge clk_i);
  endtask

  // One phase: set registers, free a run in the window, then mixed traffic
  task automatic run_phase(logic [bfa_pkg::FcountW-1:0] fc, logic [bfa_pkg::FrameW-1:0] ss,
                           int unsigned n, bit quiet);
    int unsigned lo, hi, span, first, run, j, r;
    write_reg(bfa_pkg::REG_FRAME_COUNT, fc);
    write_reg(bfa_pkg::REG_SEARCH_START, {1'b0, ss});
    @(negedge clk_i);
    gaps_on   = !quiet && ($urandom_range(0, 3) != 0);
    stalls_on = !quiet && ($urandom_range(0, 3) != 0);
    lo   = (ss / bfa_pkg::WordW) * bfa_pkg::WordW;
    hi   = (fc > bfa_pkg::MaxFrames) ? bfa_pkg::MaxFrames : fc;
    span = (hi > lo + bfa_pkg::WordW) ? hi - lo : bfa_pkg::WordW;
    if (span > 256) span = 256;
    first = lo + bfa_pkg::WordW * $urandom_range(0, span / bfa_pkg::WordW - 1);
    run   = $urandom_range(0, 1) ? 64 : 24;
    for (j = 0; j < run; j++) req_backlog.push_back(free_req(first + j));
    for (j = run; j < n; j++) begin
      r = $urandom_range(0, 99);
      if (r < 45) req_backlog.push_back(alloc_req(pick_count()));
      else if (r < 80) req_backlog.push_back(free_req(lo + $urandom_range(0, span - 1)));
      else begin
        case (r % 4)
          0: req_backlog.push_back(alloc_req(0));
          1: req_backlog.push_back(alloc_req($urandom_range(65, 127)));
          2: req_backlog.push_back(free_req(0));
          default: req_backlog.push_back(free_req($urandom_range(0, 65535)));
        endcase
      end
    end
    drain();
  endtask

  initial begin : stimulus
    int unsigned k, ss;
    foreach (frame_map[w]) frame_map[w] = '1;
    used_total = 0;
    fcount_cfg = bfa_pkg::FcountW'(bfa_pkg::MaxFrames);
    start_cfg  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners over the full frame range
    write_reg(bfa_pkg::REG_FRAME_COUNT, bfa_pkg::FcountW'(bfa_pkg::MaxFrames));
    write_reg(bfa_pkg::REG_SEARCH_START, '0);
    @(negedge clk_i);
    req_backlog.push_back(free_req(0));        // null frame rejected
    req_backlog.push_back(free_req(1));        // counter holds at zero
    req_backlog.push_back(alloc_req(0));       // zero count
    req_backlog.push_back(alloc_req(65));      // just above the largest run
    req_backlog.push_back(alloc_req(127));
    req_backlog.push_back(alloc_req(1));       // takes frame 1
    req_backlog.push_back(alloc_req(1));       // full bitmap, longest scan
    req_backlog.push_back(alloc_req(64));
    req_backlog.push_back(free_req(65535));    // top frame
    for (k = 8; k < 16; k++) req_backlog.push_back(free_req(k));
    req_backlog.push_back(alloc_req(5));       // 8-block, tail left free
    req_backlog.push_back(alloc_req(1));       // picks up the free tail
    req_backlog.push_back(alloc_req(2));       // no whole byte free
    drain();

    // Search from the last frame
    write_reg(bfa_pkg::REG_SEARCH_START, 17'd65535);
    @(negedge clk_i);
    req_backlog.push_back(alloc_req(1));
    req_backlog.push_back(alloc_req(16));
    req_backlog.push_back(alloc_req(2));
    drain();

    // Random phases across register settings, one without any idling
    run_phase(17'd64, 16'd0, 70, 1'b0);
    run_phase(17'd1024, 16'd0, 70, 1'b1);
    run_phase(17'd1300, 16'd1000, 70, 1'b0);
    run_phase(17'h1FFFF, 16'd65024, 72, 1'b0);
    run_phase(17'd0, bfa_pkg::FrameW'($urandom), 12, 1'b0);
    for (k = 0; k < 4; k++) begin
      ss = $urandom_range(64, 65000);
      run_phase(bfa_pkg::FcountW'(ss + $urandom_range(64, 700)),
                ss[bfa_pkg::FrameW-1:0], 72, 1'b0);
    end

    // Let any stray result show up
    repeat (16) @(negedge clk_i);
    $display("Sent %0d requests under %0d register writes; %0d runs placed, %0d refused.",
             sent, cfg_writes, placed, refused);
    $display("Checked %0d results, %0d mismatches.", checked, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/bfa_pkg.sv
rtl/bitmap_frame_allocator.sv
sim/tb_bitmap_frame_allocator.sv
